### sv/hfc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hfc_pkg: shared types and constants of the hdlc frame checker
// length field size, frame offsets, result codes and the x.25 crc byte update
// ----------------------------------------------------------------------------
package hfc_pkg;

   localparam int LENGTH_BITS   = 11;
   localparam int FRAME_LEN_W   = 11;
   localparam int POS_W         = LENGTH_BITS + 1;
   localparam int ADDR_W        = 4;
   localparam int SEQ_W         = 3;

   localparam logic [ADDR_W-1:0] ADDR_BYTES_RESET = ADDR_W'(2);

   localparam int CTRL_OFFSET       = 2;
   localparam int BLOCK_HI_OFFSET   = 8;
   localparam int BLOCK_LO_OFFSET   = 9;
   localparam int BLOCK_END_OFFSET  = 11;
   localparam int MIN_FRAME_LEN     = 4;

   localparam logic [15:0] CRC_INIT  = 16'hFFFF;
   localparam logic [15:0] CRC_POLY  = 16'h8408;
   localparam logic [15:0] BLOCK_TAG = 16'hC402;

   typedef enum logic [1:0] {
      KIND_I = 2'd0,
      KIND_S = 2'd1,
      KIND_U = 2'd2
   } frame_kind_type;

   typedef enum logic [2:0] {
      STATUS_OK    = 3'd0,
      STATUS_I_NR  = 3'd1,
      STATUS_I_NS  = 3'd2,
      STATUS_S_NR  = 3'd3,
      STATUS_U     = 3'd4
   } seq_status_type;

   typedef struct packed {
      logic                   crc_ok;
      frame_kind_type         frame_kind;
      seq_status_type         sequence_status;
      logic [7:0]             control_byte;
      logic                   seg_end;
      logic                   block_mode;
      logic                   block_end;
      logic [FRAME_LEN_W-1:0] frame_length;
      logic                   too_short;
   } result_type;

   function automatic logic [15:0] crc16_x25_byte(input logic [15:0] crc,
                                                  input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

### sv/hdlc_frame_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hdlc_frame_checker: hdlc frame fcs, control field and block word checker
// one byte per request; one result at the last byte of each frame
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/stall    | data byte, frame start, client N(S)/N(R)
//  rsp     | out       | rsp_valid/stall    | crc, frame kind, sequence status, fields
//  csr     | in        | csr_wr_en          | address byte count
//
//  a request is registered, then the crc byte update, position counter and
//  field captures act on it and a frame's result is registered in the result
//  stage. one request per cycle is sustained while rsp_stall is low, limited
//  by the single byte-wide crc update. synchronous reset clears the frame
//  state and empties both stages. a stalled result holds the request stage,
//  and req_stall is raised only while that stage is full and cannot drain.
// ----------------------------------------------------------------------------
module hdlc_frame_checker
   import hfc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   csr_wr_en,
   input  wire logic [ADDR_W-1:0]      csr_wr_data,

   input  wire logic                   req_valid,
   output      logic                   req_stall,
   input  wire logic [7:0]             req_data_byte,
   input  wire logic                   req_frame_start,
   input  wire logic [SEQ_W-1:0]       req_client_send_seq,
   input  wire logic [SEQ_W-1:0]       req_client_recv_seq,

   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      logic                   rsp_crc_ok,
   output      logic [1:0]             rsp_frame_kind,
   output      logic [2:0]             rsp_sequence_status,
   output      logic [7:0]             rsp_control_byte,
   output      logic                   rsp_seg_end,
   output      logic                   rsp_block_mode,
   output      logic                   rsp_block_end,
   output      logic [FRAME_LEN_W-1:0] rsp_frame_length,
   output      logic                   rsp_too_short
);

   // configuration
   logic [ADDR_W-1:0]      addr_bytes_ff;

   // request stage
   logic                   s1_valid_ff;
   logic [7:0]             s1_byte_ff;
   logic                   s1_start_ff;
   logic [SEQ_W-1:0]       s1_send_ff;
   logic [SEQ_W-1:0]       s1_recv_ff;

   // frame state
   logic                   active_ff,     active_in;
   logic [15:0]            crc_ff,        crc_in;
   logic [LENGTH_BITS-1:0] pos_ff,        pos_in;
   logic [LENGTH_BITS-1:0] len_ff,        len_in;
   logic [7:0]             format_hi_ff,  format_hi_in;
   logic [7:0]             control_ff,    control_in;
   logic [15:0]            block_word_ff, block_word_in;
   logic [7:0]             block_flag_ff, block_flag_in;
   logic [7:0]             fcs_low_ff,    fcs_low_in;
   logic [SEQ_W-1:0]       send_seq_ff,   send_seq_in;
   logic [SEQ_W-1:0]       recv_seq_ff,   recv_seq_in;

   // result stage
   logic                   rsp_valid_ff;
   result_type             result_ff,     result_in;
   logic                   result_hit;

   logic                   advance;
   logic                   s1_fire;
   logic                   req_accept;

   logic [POS_W-1:0]       pos_x;
   logic [POS_W-1:0]       len_x;
   logic [POS_W-1:0]       addr_x;
   logic [SEQ_W-1:0]       nsc1;
   logic [SEQ_W-1:0]       ns_srv;
   logic [SEQ_W-1:0]       nr_srv;

   assign advance    = !rsp_valid_ff || !rsp_stall;
   assign s1_fire    = s1_valid_ff && advance;
   assign req_stall  = s1_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      active_in     = active_ff;
      crc_in        = crc_ff;
      pos_in        = pos_ff;
      len_in        = len_ff;
      format_hi_in  = format_hi_ff;
      control_in    = control_ff;
      block_word_in = block_word_ff;
      block_flag_in = block_flag_ff;
      fcs_low_in    = fcs_low_ff;
      send_seq_in   = send_seq_ff;
      recv_seq_in   = recv_seq_ff;
      result_hit    = 1'b0;
      result_in     = '0;
      nsc1          = '0;
      ns_srv        = '0;
      nr_srv        = '0;

      // frame start clears the open frame
      if (s1_start_ff) begin
         active_in     = 1'b1;
         crc_in        = CRC_INIT;
         pos_in        = '0;
         len_in        = '0;
         format_hi_in  = '0;
         control_in    = '0;
         block_word_in = '0;
         block_flag_in = '0;
         fcs_low_in    = '0;
         send_seq_in   = s1_send_ff;
         recv_seq_in   = s1_recv_ff;
      end

      pos_x  = {1'b0, pos_in};
      len_x  = {1'b0, len_in};
      addr_x = POS_W'(addr_bytes_ff);

      if (active_in) begin
         if (pos_x == POS_W'(0)) begin
            format_hi_in = s1_byte_ff;
         end
         if (pos_x == POS_W'(1)) begin
            len_in = LENGTH_BITS'({format_hi_in, s1_byte_ff});
            len_x  = {1'b0, len_in};
         end
         if (pos_x == POS_W'(1) && len_x < POS_W'(MIN_FRAME_LEN)) begin
            // short length field, frame closes at once
            result_hit             = 1'b1;
            result_in.seg_end      = !format_hi_in[3];
            result_in.frame_length = FRAME_LEN_W'(len_in);
            result_in.too_short    = 1'b1;
            result_in.frame_kind   = KIND_I;
            result_in.sequence_status = STATUS_OK;
            active_in              = 1'b0;
         end else begin
            if (pos_x < POS_W'(2) || pos_x + POS_W'(2) < len_x) begin
               crc_in = crc16_x25_byte(crc_in, s1_byte_ff);
            end
            if (pos_x >= POS_W'(2) && pos_x + POS_W'(2) == len_x) begin
               fcs_low_in = s1_byte_ff;
            end
            if (pos_x == addr_x + POS_W'(CTRL_OFFSET)) begin
               control_in = s1_byte_ff;
            end
            if (pos_x == addr_x + POS_W'(BLOCK_HI_OFFSET)) begin
               block_word_in[15:8] = s1_byte_ff;
            end
            if (pos_x == addr_x + POS_W'(BLOCK_LO_OFFSET)) begin
               block_word_in[7:0] = s1_byte_ff;
            end
            if (pos_x == addr_x + POS_W'(BLOCK_END_OFFSET)) begin
               block_flag_in = s1_byte_ff;
            end

            if (pos_x >= POS_W'(2) && pos_x + POS_W'(1) == len_x) begin
               // last byte: high byte of the fcs
               nsc1   = send_seq_in + SEQ_W'(1);
               ns_srv = control_in[3:1];
               nr_srv = control_in[7:5];
               result_hit             = 1'b1;
               result_in.crc_ok       = (~crc_in) == {s1_byte_ff, fcs_low_in};
               result_in.control_byte = control_in;
               result_in.seg_end      = !format_hi_in[3];
               result_in.block_mode   = block_word_in == BLOCK_TAG;
               result_in.block_end    = block_flag_in != 8'h00;
               result_in.frame_length = FRAME_LEN_W'(len_in);
               result_in.too_short    = 1'b0;
               if (!control_in[0]) begin
                  result_in.frame_kind = KIND_I;
                  if (nsc1 != nr_srv) begin
                     result_in.sequence_status = STATUS_I_NR;
                  end else if (recv_seq_in != ns_srv) begin
                     result_in.sequence_status = STATUS_I_NS;
                  end else begin
                     result_in.sequence_status = STATUS_OK;
                  end
               end else if (!control_in[1]) begin
                  result_in.frame_kind      = KIND_S;
                  result_in.sequence_status = (nsc1 != nr_srv) ? STATUS_S_NR : STATUS_OK;
               end else begin
                  result_in.frame_kind      = KIND_U;
                  result_in.sequence_status = STATUS_U;
               end
               active_in = 1'b0;
            end else begin
               pos_in = pos_in + LENGTH_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_bytes_ff <= ADDR_BYTES_RESET;
      end else if (csr_wr_en) begin
         addr_bytes_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance || !s1_valid_ff) begin
         s1_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_byte_ff  <= req_data_byte;
         s1_start_ff <= req_frame_start;
         s1_send_ff  <= req_client_send_seq;
         s1_recv_ff  <= req_client_recv_seq;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         crc_ff        <= CRC_INIT;
         pos_ff        <= '0;
         len_ff        <= '0;
         format_hi_ff  <= '0;
         control_ff    <= '0;
         block_word_ff <= '0;
         block_flag_ff <= '0;
         fcs_low_ff    <= '0;
         send_seq_ff   <= '0;
         recv_seq_ff   <= '0;
      end else if (s1_fire) begin
         active_ff     <= active_in;
         crc_ff        <= crc_in;
         pos_ff        <= pos_in;
         len_ff        <= len_in;
         format_hi_ff  <= format_hi_in;
         control_ff    <= control_in;
         block_word_ff <= block_word_in;
         block_flag_ff <= block_flag_in;
         fcs_low_ff    <= fcs_low_in;
         send_seq_ff   <= send_seq_in;
         recv_seq_ff   <= recv_seq_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_fire && result_hit;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && result_hit) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_crc_ok          = result_ff.crc_ok;
   assign rsp_frame_kind      = result_ff.frame_kind;
   assign rsp_sequence_status = result_ff.sequence_status;
   assign rsp_control_byte    = result_ff.control_byte;
   assign rsp_seg_end         = result_ff.seg_end;
   assign rsp_block_mode      = result_ff.block_mode;
   assign rsp_block_end       = result_ff.block_end;
   assign rsp_frame_length    = result_ff.frame_length;
   assign rsp_too_short       = result_ff.too_short;

`ifndef SYNTH
   // short frame results carry no crc match and a small length
   a_short_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_too_short |->
         !rsp_crc_ok && rsp_frame_length < FRAME_LEN_W'(MIN_FRAME_LEN))
      else $error("short frame result with bad fields");

   // bytes outside an open frame never give a result
   a_idle_byte: assert property (@(posedge clock) disable iff (reset)
      s1_fire && !s1_start_ff && !active_ff |=> !rsp_valid)
      else $error("result from a byte outside a frame");

   // u-frames always report the u-frame status
   a_u_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_kind == KIND_U |-> rsp_sequence_status == STATUS_U)
      else $error("u-frame with wrong sequence status");
`endif

endmodule
`default_nettype wire
